// ----- sv/vcpi_pkg.sv -----
// ============================================================================
// vcpi_pkg - shared types and constants for the video chip CPU port
// Beat layouts, access kinds, control commands and register tables.
// ============================================================================
package vcpi_pkg;

    // Video memory geometry (16K entries, covering the whole 14-bit address space)
    localparam int VRAM_DEPTH = 16384;
    localparam int VRAM_AW    = (VRAM_DEPTH > 1) ? $clog2(VRAM_DEPTH) : 1;
    localparam int ADDR_W     = 14;

    // Access kinds carried by an input beat
    typedef enum logic [2:0] {
        KIND_DATA_READ    = 3'd0,
        KIND_STATUS_READ  = 3'd1,
        KIND_DATA_WRITE   = 3'd2,
        KIND_CONTROL      = 3'd3,
        KIND_VBLANK       = 3'd4
    } kind_t;

    // Command codes in the top two bits of the second control byte
    localparam logic [1:0] CMD_READ_SETUP  = 2'b00;
    localparam logic [1:0] CMD_WRITE_SETUP = 2'b01;
    localparam logic [1:0] CMD_REG_WRITE   = 2'b10;
    localparam logic [1:0] CMD_NONE        = 2'b11;

    // Status byte handling
    localparam logic [7:0] STATUS_READ_KEEP = 8'h5F;
    localparam logic [7:0] STATUS_FRAME     = 8'h80;

    // Internal register write masks and reset values
    localparam logic [7:0] REG_MASK [8] = '{
        8'h03, 8'hFB, 8'h0F, 8'hFF, 8'h07, 8'h7F, 8'h07, 8'hFF
    };
    localparam logic [7:0] REG_RESET [8] = '{
        8'h36, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'h00
    };

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        nmi_request;
        logic [2:0]  display_mode;
    } out_item_t;

    // Request from the port logic to video memory
    typedef struct packed {
        logic               we;
        logic               re;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } vram_req_t;

endpackage

// ----- sv/video_chip_cpu_port_interface.sv -----
// A result beat is offered from the result register after its request beat has
// passed the input register and decode. Throughput: one beat per cycle while
// results drain and memory is idle, set by the single-pass decode stage and
// the registered read port of video memory. Reset: rst_n clears all port state
// at once, then 16384 memory entries are zero-filled while req_ready is low.
// ============================================================================
// video_chip_cpu_port_interface - CPU port of a tile video chip
// Input register, decode stage with video memory, and result register.
// ============================================================================
module video_chip_cpu_port_interface (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  vcpi_pkg::in_item_t    req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output vcpi_pkg::out_item_t   rsp
);

    logic                 item_valid_reg;
    vcpi_pkg::in_item_t   item_reg;
    logic                 out_valid_reg;
    vcpi_pkg::out_item_t  out_reg;
    logic                 go;
    logic                 busy;
    logic [7:0]           mem_rdata;
    vcpi_pkg::vram_req_t  mem_req;
    vcpi_pkg::out_item_t  result;

    // Move the held beat on when the result slot is free or draining
    assign go        = item_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !busy && (!item_valid_reg || go);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            item_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            item_reg <= req;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_reg <= result;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    vcpi_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .item      (item_reg),
        .mem_rdata (mem_rdata),
        .mem_req   (mem_req),
        .result    (result)
    );

    vcpi_vram u_vram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (busy)
    );

endmodule

// ----- sv/vcpi_vram.sv -----
// ============================================================================
// vcpi_vram - video memory with power-on clearing sweep
// One write and one registered read per cycle; zero-fills every entry
// after reset, one entry per cycle, and flags busy meanwhile.
// ============================================================================
module vcpi_vram (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vcpi_pkg::vram_req_t          req,
    output logic [7:0]                   rdata,
    output logic                         busy
);

    logic [7:0]                   mem [vcpi_pkg::VRAM_DEPTH];
    logic [vcpi_pkg::VRAM_AW-1:0] clr_cnt_reg;
    logic [vcpi_pkg::VRAM_AW-1:0] clr_cnt_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic [7:0]                   rdata_reg;

    // Advance the clearing sweep until the last entry is written
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            if (clr_cnt_reg == vcpi_pkg::VRAM_AW'(vcpi_pkg::VRAM_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    // Store: sweep zeros first, then take port writes
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= 8'h00;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    // Registered read; hold the data between reads
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

// ----- sv/vcpi_core.sv -----
// ============================================================================
// vcpi_core - port state and single-pass access decode
// Holds the address, byte latch, read-ahead, status and internal
// registers, and works out one beat's result and state update.
// ============================================================================
module vcpi_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  vcpi_pkg::in_item_t    item,
    input  logic [7:0]            mem_rdata,
    output vcpi_pkg::vram_req_t   mem_req,
    output vcpi_pkg::out_item_t   result
);

    logic [vcpi_pkg::ADDR_W-1:0] addr_reg;
    logic [vcpi_pkg::ADDR_W-1:0] addr_next;
    logic [7:0]                  ra_reg;
    logic [7:0]                  ra_next;
    logic                        ra_mem_reg;
    logic                        ra_mem_next;
    logic                        first_reg;
    logic                        first_next;
    logic [7:0]                  regs_reg [8];
    logic [7:0]                  regs_next [8];
    logic [7:0]                  status_reg;
    logic [7:0]                  status_next;
    logic [2:0]                  mode_reg;
    logic [2:0]                  mode_next;

    logic [7:0]                  ra_cur;
    logic [vcpi_pkg::ADDR_W-1:0] ctrl_addr;
    logic [vcpi_pkg::ADDR_W-1:0] mem_addr;
    logic [1:0]                  cmd;
    logic [2:0]                  reg_sel;
    logic [7:0]                  reg_val;
    logic [7:0]                  new_r0;
    logic [7:0]                  new_r1;

    // Fold a 14-bit address onto video memory, at most 15 wraps deep
    function automatic logic [vcpi_pkg::VRAM_AW-1:0] vram_index(
        input logic [vcpi_pkg::ADDR_W-1:0] a
    );
        logic [17:0] r;
        r = {4'b0000, a};
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= 18'(vcpi_pkg::VRAM_DEPTH << k))
            begin
                r = r - 18'(vcpi_pkg::VRAM_DEPTH << k);
            end
        end
        return r[vcpi_pkg::VRAM_AW-1:0];
    endfunction

    // Read-ahead lives in the memory read register until overwritten
    assign ra_cur    = ra_mem_reg ? mem_rdata : ra_reg;
    assign ctrl_addr = {item.data_byte[5:0], addr_reg[7:0]};
    assign mem_addr  = (item.kind == vcpi_pkg::KIND_CONTROL) ? ctrl_addr : addr_reg;
    assign cmd       = item.data_byte[7:6];
    assign reg_sel   = item.data_byte[2:0];
    assign reg_val   = addr_reg[7:0] & vcpi_pkg::REG_MASK[reg_sel];

    // Decode the beat and work out next state and result
    always_comb
    begin
        addr_next   = addr_reg;
        ra_next     = ra_reg;
        ra_mem_next = ra_mem_reg;
        first_next  = first_reg;
        regs_next   = regs_reg;
        status_next = status_reg;
        mode_next   = mode_reg;
        new_r0      = regs_reg[0];
        new_r1      = regs_reg[1];

        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = vram_index(mem_addr);
        mem_req.wdata = item.data_byte;

        result.read_byte   = 8'h00;
        result.nmi_request = 1'b0;

        case (item.kind)
            vcpi_pkg::KIND_DATA_READ:
            begin
                first_next       = 1'b1;
                result.read_byte = ra_cur;
                mem_req.re       = go;
                ra_mem_next      = 1'b1;
                addr_next        = addr_reg + 1'b1;
            end
            vcpi_pkg::KIND_STATUS_READ:
            begin
                first_next       = 1'b1;
                result.read_byte = status_reg;
                status_next      = status_reg & vcpi_pkg::STATUS_READ_KEEP;
            end
            vcpi_pkg::KIND_DATA_WRITE:
            begin
                first_next  = 1'b1;
                ra_next     = item.data_byte;
                ra_mem_next = 1'b0;
                mem_req.we  = go;
                addr_next   = addr_reg + 1'b1;
            end
            vcpi_pkg::KIND_CONTROL:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    addr_next  = {addr_reg[13:8], item.data_byte};
                end
                else
                begin
                    first_next = 1'b1;
                    addr_next  = ctrl_addr;
                    case (cmd)
                        vcpi_pkg::CMD_READ_SETUP:
                        begin
                            mem_req.re  = go;
                            ra_mem_next = 1'b1;
                            addr_next   = ctrl_addr + 1'b1;
                        end
                        vcpi_pkg::CMD_REG_WRITE:
                        begin
                            regs_next[reg_sel] = reg_val;
                            if (reg_sel == 3'd0)
                            begin
                                new_r0 = reg_val;
                            end
                            if (reg_sel == 3'd1)
                            begin
                                new_r1 = reg_val;
                                result.nmi_request = !regs_reg[1][5] && reg_val[5]
                                                     && status_reg[7];
                            end
                            if (reg_sel[2:1] == 2'b00)
                            begin
                                mode_next = {new_r1[3], new_r0[1], new_r1[4]};
                            end
                        end
                        default:
                        begin
                            // write setup or no action: address only
                        end
                    endcase
                end
            end
            vcpi_pkg::KIND_VBLANK:
            begin
                result.nmi_request = regs_reg[1][5] && !status_reg[7];
                status_next        = status_reg | vcpi_pkg::STATUS_FRAME;
            end
            default:
            begin
                // unknown kind: leave state alone
            end
        endcase

        result.display_mode = mode_next;
    end

    // Commit the update only when the beat moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            ra_reg     <= 8'h00;
            ra_mem_reg <= 1'b0;
            first_reg  <= 1'b1;
            regs_reg   <= vcpi_pkg::REG_RESET;
            status_reg <= 8'h00;
            mode_reg   <= 3'b000;
        end
        else if (go)
        begin
            addr_reg   <= addr_next;
            ra_reg     <= ra_next;
            ra_mem_reg <= ra_mem_next;
            first_reg  <= first_next;
            regs_reg   <= regs_next;
            status_reg <= status_next;
            mode_reg   <= mode_next;
        end
    end

endmodule

// ----- dv/video_chip_cpu_port_interface_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// video_chip_cpu_port_interface_tb - self-checking bench for the CPU port
// Drives request beats through a directed table and then random traffic built
// mostly from well-formed control pairs. Each taken beat is run through a
// shadow of the port (address latch, read-ahead, registers, status, memory)
// and the response beats are compared field by field, in order.
// ============================================================================
module video_chip_cpu_port_interface_tb;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_BEATS    = 667;
    localparam int DIR_N          = 28;

    // Write masks and reset contents of the internal registers
    localparam logic [7:0] WRITE_MASKS [8] = '{
        8'h03, 8'hFB, 8'h0F, 8'hFF, 8'h07, 8'h7F, 8'h07, 8'hFF
    };
    localparam logic [7:0] REG_DEFAULTS [8] = '{
        8'h36, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'h00
    };
    localparam logic [7:0] FRAME_FLAG          = 8'h80;
    localparam logic [7:0] KEEP_ON_STATUS_READ = 8'h5F;

    localparam vcpi_pkg::out_item_t RSP_QUIET = '0;

    typedef struct packed {
        vcpi_pkg::kind_t     kind;
        logic [7:0]          data;
        logic                lit;
        vcpi_pkg::out_item_t expv;
    } dir_row_t;

    // Directed beats; expv is only used where lit is set
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{vcpi_pkg::KIND_DATA_READ,   8'h00, 1'b1, RSP_QUIET},  // buffer empty after reset
        '{vcpi_pkg::KIND_STATUS_READ, 8'h00, 1'b1, RSP_QUIET},
        '{vcpi_pkg::KIND_VBLANK,      8'h00, 1'b1, RSP_QUIET},  // interrupt still disabled
        '{vcpi_pkg::KIND_STATUS_READ, 8'h00, 1'b1, '{8'h80, 1'b0, 3'd0}},
        '{vcpi_pkg::kind_t'(3'd7),    8'hFF, 1'b1, RSP_QUIET},  // unknown kind
        '{vcpi_pkg::KIND_CONTROL,     8'hFF, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'h81, 1'b0, RSP_QUIET},  // reg1 all ones masked to FB, enable
        '{vcpi_pkg::KIND_VBLANK,      8'h00, 1'b0, RSP_QUIET},  // interrupt on vblank
        '{vcpi_pkg::KIND_CONTROL,     8'h00, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'h81, 1'b0, RSP_QUIET},  // reg1 cleared
        '{vcpi_pkg::KIND_CONTROL,     8'h20, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'h81, 1'b0, RSP_QUIET},  // interrupt on enable
        '{vcpi_pkg::KIND_CONTROL,     8'h00, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'h40, 1'b0, RSP_QUIET},  // write setup at zero
        '{vcpi_pkg::KIND_DATA_WRITE,  8'h00, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_DATA_WRITE,  8'hFF, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_DATA_WRITE,  8'hA5, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'h00, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'h00, 1'b0, RSP_QUIET},  // read setup at zero
        '{vcpi_pkg::KIND_DATA_READ,   8'h00, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_DATA_READ,   8'h00, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'hFF, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'h3F, 1'b0, RSP_QUIET},  // read setup at top, wraps
        '{vcpi_pkg::KIND_CONTROL,     8'h12, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_STATUS_READ, 8'h00, 1'b0, RSP_QUIET},  // ends the half pair, low byte kept
        '{vcpi_pkg::KIND_CONTROL,     8'hC0, 1'b0, RSP_QUIET},
        '{vcpi_pkg::KIND_CONTROL,     8'hFF, 1'b0, RSP_QUIET},  // no-action command
        '{vcpi_pkg::kind_t'(3'd5),    8'hAA, 1'b0, RSP_QUIET}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    vcpi_pkg::in_item_t  req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    vcpi_pkg::out_item_t rsp;

    // Shadow of the port state
    logic [7:0]  sh_vram [vcpi_pkg::VRAM_DEPTH];
    logic [13:0] sh_addr;
    logic [7:0]  sh_buf;
    logic        sh_first;
    logic [7:0]  sh_regs [8];
    logic [7:0]  sh_status;
    logic [2:0]  sh_mode;

    vcpi_pkg::out_item_t awaited_rsp [$];
    int        mismatch_cnt = 0;
    int        snd_idle_pct = 36;
    int        rcv_idle_pct = 66;
    int        hold_req     = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;
    int        quiet_cycles = 0;

    video_chip_cpu_port_interface uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int i = 0; i < vcpi_pkg::VRAM_DEPTH; i++)
            sh_vram[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            sh_regs[i] = REG_DEFAULTS[i];
        sh_addr   = '0;
        sh_buf    = 8'h00;
        sh_first  = 1'b1;
        sh_status = 8'h00;
        sh_mode   = 3'd0;
    end

    // Advance the shadow by one request beat and return the response it causes
    function automatic vcpi_pkg::out_item_t predict_port_access(input vcpi_pkg::in_item_t it);
        vcpi_pkg::out_item_t o;
        logic [2:0]          r;
        logic                was_enabled;
        o = '0;
        case (it.kind)
            vcpi_pkg::KIND_DATA_READ:
            begin
                sh_first    = 1'b1;
                o.read_byte = sh_buf;
                sh_buf      = sh_vram[sh_addr % vcpi_pkg::VRAM_DEPTH];
                sh_addr     = sh_addr + 14'd1;
            end
            vcpi_pkg::KIND_STATUS_READ:
            begin
                sh_first    = 1'b1;
                o.read_byte = sh_status;
                sh_status   = sh_status & KEEP_ON_STATUS_READ;
            end
            vcpi_pkg::KIND_DATA_WRITE:
            begin
                sh_first = 1'b1;
                sh_buf   = it.data_byte;
                sh_vram[sh_addr % vcpi_pkg::VRAM_DEPTH] = it.data_byte;
                sh_addr  = sh_addr + 14'd1;
            end
            vcpi_pkg::KIND_CONTROL:
            begin
                if (sh_first)
                begin
                    sh_first     = 1'b0;
                    sh_addr[7:0] = it.data_byte;
                end
                else
                begin
                    sh_first      = 1'b1;
                    sh_addr[13:8] = it.data_byte[5:0];
                    case (it.data_byte[7:6])
                        vcpi_pkg::CMD_READ_SETUP:
                        begin
                            sh_buf  = sh_vram[sh_addr % vcpi_pkg::VRAM_DEPTH];
                            sh_addr = sh_addr + 14'd1;
                        end
                        vcpi_pkg::CMD_REG_WRITE:
                        begin
                            r           = it.data_byte[2:0];
                            was_enabled = sh_regs[1][5];
                            sh_regs[r]  = sh_addr[7:0] & WRITE_MASKS[r];
                            if (r == 3'd1 && !was_enabled && sh_regs[1][5]
                                && (sh_status & FRAME_FLAG) != 8'h00)
                                o.nmi_request = 1'b1;
                            if (r < 3'd2)
                                sh_mode = {sh_regs[1][3], sh_regs[0][1], sh_regs[1][4]};
                        end
                        default: ;
                    endcase
                end
            end
            vcpi_pkg::KIND_VBLANK:
            begin
                if (sh_regs[1][5] && (sh_status & FRAME_FLAG) == 8'h00)
                    o.nmi_request = 1'b1;
                sh_status = sh_status | FRAME_FLAG;
            end
            default: ;
        endcase
        o.display_mode = sh_mode;
        return o;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Offer one request beat, hold it until taken, then queue its response
    task automatic push_beat(input vcpi_pkg::in_item_t it, input bit use_lit,
                             input vcpi_pkg::out_item_t lit);
        vcpi_pkg::out_item_t predicted;
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = predict_port_access(it);
        awaited_rsp.push_back(use_lit ? lit : predicted);
    endtask

    // Drop valid and wait for every queued response
    task automatic pause_until_drained();
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic make_beat(input vcpi_pkg::kind_t k, input logic [7:0] d,
                             output vcpi_pkg::in_item_t it);
        it.kind      = k;
        it.data_byte = d;
    endtask

    // Send one random access; control pairs are the bulk of the traffic
    task automatic send_random_beats(inout int sent);
        vcpi_pkg::in_item_t it;
        int         pick;
        int         c;
        logic [7:0] lo;
        logic [1:0] cmd;
        logic [5:0] hi;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            make_beat(vcpi_pkg::KIND_DATA_READ, 8'($urandom), it);
        else if (pick < 28)
            make_beat(vcpi_pkg::KIND_STATUS_READ, 8'($urandom), it);
        else if (pick < 48)
            make_beat(vcpi_pkg::KIND_DATA_WRITE, 8'($urandom), it);
        else if (pick < 83)
        begin
            c = $urandom_range(0, 9);
            if (c < 3)
                cmd = vcpi_pkg::CMD_READ_SETUP;
            else if (c < 5)
                cmd = vcpi_pkg::CMD_WRITE_SETUP;
            else if (c < 9)
                cmd = vcpi_pkg::CMD_REG_WRITE;
            else
                cmd = vcpi_pkg::CMD_NONE;
            if (cmd == vcpi_pkg::CMD_REG_WRITE || $urandom_range(0, 3) == 0)
                lo = 8'($urandom);
            else
                lo = 8'($urandom_range(0, 15));
            if (cmd == vcpi_pkg::CMD_REG_WRITE || $urandom_range(0, 3) == 0)
                hi = 6'($urandom);
            else
                hi = 6'd0;
            make_beat(vcpi_pkg::KIND_CONTROL, lo, it);
            push_beat(it, 1'b0, RSP_QUIET);
            sent++;
            make_beat(vcpi_pkg::KIND_CONTROL, {cmd, hi}, it);
        end
        else if (pick < 91)
            make_beat(vcpi_pkg::KIND_VBLANK, 8'($urandom), it);
        else if (pick < 96)
            make_beat(vcpi_pkg::KIND_CONTROL, 8'($urandom), it);   // lone byte, broken pair
        else
            make_beat(vcpi_pkg::kind_t'(3'($urandom_range(5, 7))), 8'($urandom), it);
        push_beat(it, 1'b0, RSP_QUIET);
        sent++;
    endtask

    // Stimulus
    initial
    begin
        vcpi_pkg::in_item_t it;
        dir_row_t           row;
        int                 sent;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_TAB[i];
            make_beat(row.kind, row.data, it);
            push_beat(it, row.lit, row.expv);
        end
        pause_until_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin snd_idle_pct = 36; rcv_idle_pct = 66; end
                1: begin snd_idle_pct = 66; rcv_idle_pct = 36; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                send_random_beats(sent);
                // Stall the response side for a long stretch once
                if (phase == 0 && sent >= 200 && hold_req == 0)
                    hold_req = 1;
            end
            pause_until_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Response side readiness, with the long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Compare each response beat with the oldest queued one
    always @(posedge clk)
    begin
        vcpi_pkg::out_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
                report_mismatch($sformatf("response beat with nothing queued: %h", rsp));
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.read_byte !== want.read_byte)
                    report_mismatch($sformatf("read_byte %h, want %h",
                                              rsp.read_byte, want.read_byte));
                if (rsp.nmi_request !== want.nmi_request)
                    report_mismatch($sformatf("nmi_request %b, want %b",
                                              rsp.nmi_request, want.nmi_request));
                if (rsp.display_mode !== want.display_mode)
                    report_mismatch($sformatf("display_mode %0d, want %0d",
                                              rsp.display_mode, want.display_mode));
            end
        end
    end

    // End the run when neither side moves a beat for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
